>>> src/beal_pkg.sv
// ----------------------------------------------------------------------------
// beal_pkg
// Shared types and constants for the button edge / auto-repeat conditioner.
// ----------------------------------------------------------------------------
package beal_pkg;

    localparam int BTN_W      = 16;
    localparam int STICK_W    = 8;
    localparam int PORT_W     = 2;
    localparam int CNT_W      = 18;
    localparam int CFG_W      = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_W-1:0] FIRST_DELAY_RST = 16'd30;
    localparam logic [CFG_W-1:0] INTERVAL_RST    = 16'd5;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_PUBLISH = 1'b1;

    localparam logic REG_FIRST_DELAY = 1'b0;
    localparam logic REG_INTERVAL    = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic [PORT_W-1:0]         port;
        logic [BTN_W-1:0]          buttons;
        logic signed [STICK_W-1:0] stick_x;
        logic signed [STICK_W-1:0] stick_y;
        logic                      fault;
    } item_t;

    typedef struct packed {
        logic [BTN_W-1:0]          held;
        logic [BTN_W-1:0]          pressed;
        logic [BTN_W-1:0]          repeats;
        logic [BTN_W-1:0]          released;
        logic signed [STICK_W-1:0] stick_x;
        logic signed [STICK_W-1:0] stick_y;
    } snap_t;

    typedef struct packed {
        snap_t snap;
        logic  faulted;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] first_delay;
        logic [CFG_W-1:0] interval;
    } cfg_t;

endpackage

>>> src/beal_regs.sv
// ----------------------------------------------------------------------------
// beal_regs
// APB register file holding the repeat delay and repeat interval.
// ----------------------------------------------------------------------------
module beal_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [beal_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [beal_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [beal_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output beal_pkg::cfg_t                    cfg
);
    import beal_pkg::*;

    logic [CFG_W-1:0] first_delay_reg;
    logic [CFG_W-1:0] interval_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_delay_reg <= FIRST_DELAY_RST;
            interval_reg    <= INTERVAL_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_FIRST_DELAY: first_delay_reg <= pwdata[CFG_W-1:0];
                REG_INTERVAL:    interval_reg    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FIRST_DELAY: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, first_delay_reg};
            REG_INTERVAL:    prdata = {{(APB_DATA_W-CFG_W){1'b0}}, interval_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.first_delay = first_delay_reg;
    assign cfg.interval    = interval_reg;

endmodule

>>> src/beal_in_stage.sv
// ----------------------------------------------------------------------------
// beal_in_stage
// Input register: captures one item and holds it until the bank consumes it.
// ----------------------------------------------------------------------------
module beal_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  beal_pkg::item_t s_item,
    input  logic            consume,
    output logic            item_valid,
    output beal_pkg::item_t item
);
    import beal_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || consume;
    assign valid_next = s_valid && s_ready ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> src/beal_port_bank.sv
// ----------------------------------------------------------------------------
// beal_port_bank
// Per-port state: edge detection, repeat countdown, accumulators, snapshots.
// ----------------------------------------------------------------------------
module beal_port_bank #(
    parameter int PORT_COUNT = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  beal_pkg::item_t   item,
    input  beal_pkg::cfg_t    cfg,
    output beal_pkg::result_t result
);
    import beal_pkg::*;

    localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    logic [BTN_W-1:0]          last_buttons_reg [PORT_COUNT];
    logic signed [STICK_W-1:0] last_sx_reg      [PORT_COUNT];
    logic signed [STICK_W-1:0] last_sy_reg      [PORT_COUNT];
    logic [BTN_W-1:0]          press_acc_reg    [PORT_COUNT];
    logic [BTN_W-1:0]          release_acc_reg  [PORT_COUNT];
    logic [BTN_W-1:0]          repeat_acc_reg   [PORT_COUNT];
    logic signed [CNT_W-1:0]   countdown_reg    [PORT_COUNT];
    logic                      fault_reg        [PORT_COUNT];
    snap_t                     snap_reg         [PORT_COUNT];

    logic [31:0]             port_ext;
    logic                    in_range;
    logic [IDX_W-1:0]        idx;
    logic [BTN_W-1:0]        prev;
    logic [BTN_W-1:0]        diff;
    logic [BTN_W-1:0]        presses;
    logic [BTN_W-1:0]        releases;
    logic [BTN_W-1:0]        rep;
    logic signed [CNT_W-1:0] cnt_dec;
    logic signed [CNT_W-1:0] countdown_next;
    snap_t                   fresh_snap;

    assign port_ext = 32'(item.port);
    assign in_range = port_ext < PORT_COUNT;
    assign idx      = in_range ? port_ext[IDX_W-1:0] : '0;

    assign prev     = last_buttons_reg[idx];
    assign diff     = item.buttons ^ prev;
    assign presses  = diff & item.buttons;
    assign releases = diff & prev;
    assign cnt_dec  = countdown_reg[idx] - CNT_W'(1);

    always_comb begin
        if (diff != '0) begin
            rep            = presses;
            countdown_next = CNT_W'(cfg.first_delay);
        end else if (cnt_dec > 0) begin
            rep            = '0;
            countdown_next = cnt_dec;
        end else begin
            rep            = item.buttons;
            countdown_next = CNT_W'(cfg.interval);
        end
    end

    assign fresh_snap.held     = last_buttons_reg[idx];
    assign fresh_snap.pressed  = press_acc_reg[idx];
    assign fresh_snap.repeats  = repeat_acc_reg[idx];
    assign fresh_snap.released = release_acc_reg[idx];
    assign fresh_snap.stick_x  = last_sx_reg[idx];
    assign fresh_snap.stick_y  = last_sy_reg[idx];

    always_comb begin
        if (!in_range) begin
            result.snap    = '0;
            result.faulted = 1'b1;
        end else if (fault_reg[idx]) begin
            result.snap    = snap_reg[idx];
            result.faulted = 1'b1;
        end else begin
            result.snap    = fresh_snap;
            result.faulted = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PORT_COUNT; i++) begin
                last_buttons_reg[i] <= '0;
                last_sx_reg[i]      <= '0;
                last_sy_reg[i]      <= '0;
                press_acc_reg[i]    <= '0;
                release_acc_reg[i]  <= '0;
                repeat_acc_reg[i]   <= '0;
                countdown_reg[i]    <= CNT_W'(FIRST_DELAY_RST);
                fault_reg[i]        <= 1'b0;
                snap_reg[i]         <= '0;
            end
        end else if (fire && in_range) begin
            unique case (item.cmd)
                CMD_SAMPLE: begin
                    fault_reg[idx] <= item.fault;
                    if (!item.fault) begin
                        last_buttons_reg[idx] <= item.buttons;
                        last_sx_reg[idx]      <= item.stick_x;
                        last_sy_reg[idx]      <= item.stick_y;
                        press_acc_reg[idx]    <= press_acc_reg[idx] | presses;
                        release_acc_reg[idx]  <= release_acc_reg[idx] | releases;
                        repeat_acc_reg[idx]   <= repeat_acc_reg[idx] | rep;
                        countdown_reg[idx]    <= countdown_next;
                    end
                end
                CMD_PUBLISH: begin
                    if (!fault_reg[idx]) begin
                        snap_reg[idx]        <= fresh_snap;
                        press_acc_reg[idx]   <= '0;
                        release_acc_reg[idx] <= '0;
                        repeat_acc_reg[idx]  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> src/beal_out_stage.sv
// ----------------------------------------------------------------------------
// beal_out_stage
// Result register: holds one published snapshot until the sink takes it.
// ----------------------------------------------------------------------------
module beal_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  beal_pkg::result_t load_data,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output beal_pkg::result_t m_data
);
    import beal_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> src/button_edge_autorepeat_latch_core.sv
// ----------------------------------------------------------------------------
// button_edge_autorepeat_latch_core
// A publish item goes through the input register, then the result register.
// Throughput: one item per cycle unless a publish waits on a full result
// register; the per-port update sits in one stage.
// A sample causes no result; a stalled result register holds only publishes.
// Reset: synchronous, active low; clears all port state, snapshots and
// restores the repeat delay (30) and interval (5).
// ----------------------------------------------------------------------------
module button_edge_autorepeat_latch_core #(
    parameter int PORT_COUNT = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [beal_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [beal_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [beal_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [beal_pkg::PORT_W-1:0]       s_port,
    input  logic [beal_pkg::BTN_W-1:0]        s_buttons_now,
    input  logic signed [beal_pkg::STICK_W-1:0] s_stick_horizontal,
    input  logic signed [beal_pkg::STICK_W-1:0] s_stick_vertical,
    input  logic                              s_read_fault,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [beal_pkg::BTN_W-1:0]        m_held_buttons,
    output logic [beal_pkg::BTN_W-1:0]        m_pressed_since,
    output logic [beal_pkg::BTN_W-1:0]        m_repeat_since,
    output logic [beal_pkg::BTN_W-1:0]        m_released_since,
    output logic signed [beal_pkg::STICK_W-1:0] m_stick_out_x,
    output logic signed [beal_pkg::STICK_W-1:0] m_stick_out_y,
    output logic                              m_port_faulted
);
    import beal_pkg::*;

    cfg_t    cfg;
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    fire;
    logic    can_load;
    result_t result;
    result_t m_data;

    assign s_item.cmd     = s_cmd;
    assign s_item.port    = s_port;
    assign s_item.buttons = s_buttons_now;
    assign s_item.stick_x = s_stick_horizontal;
    assign s_item.stick_y = s_stick_vertical;
    assign s_item.fault   = s_read_fault;

    assign fire = item_valid && (item.cmd == CMD_SAMPLE || can_load);

    beal_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    beal_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .consume    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    beal_port_bank #(
        .PORT_COUNT (PORT_COUNT)
    ) u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    beal_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && item.cmd == CMD_PUBLISH),
        .load_data (result),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_held_buttons   = m_data.snap.held;
    assign m_pressed_since  = m_data.snap.pressed;
    assign m_repeat_since   = m_data.snap.repeats;
    assign m_released_since = m_data.snap.released;
    assign m_stick_out_x    = m_data.snap.stick_x;
    assign m_stick_out_y    = m_data.snap.stick_y;
    assign m_port_faulted   = m_data.faulted;

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - button edge / auto-repeat conditioner testbench
// Drives sample and publish transfers into button_edge_autorepeat_latch_core
// with random gaps on the input side and random stalls on the result side.
// A scoreboard keeps its own per-port copy of buttons, sticks, accumulators,
// repeat countdowns, fault flags and snapshots. It predicts every published
// snapshot and compares it field by field with what the block returns. The
// repeat delay and interval are reprogrammed over the APB port between
// phases, including zero and full-scale settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import beal_pkg::*;

    localparam int PORTS       = 4;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 100;

    class snapshot_scoreboard;
        logic [CFG_W-1:0]          first_delay;
        logic [CFG_W-1:0]          interval;
        logic [BTN_W-1:0]          held [PORTS];
        logic [BTN_W-1:0]          press_acc [PORTS];
        logic [BTN_W-1:0]          release_acc [PORTS];
        logic [BTN_W-1:0]          repeat_acc [PORTS];
        logic signed [STICK_W-1:0] last_x [PORTS];
        logic signed [STICK_W-1:0] last_y [PORTS];
        int                        countdown [PORTS];
        logic                      faulted [PORTS];
        snap_t                     snaps [PORTS];
        result_t                   snapshot_q [$];
        int                        errors;

        function new();
            first_delay = FIRST_DELAY_RST;
            interval    = INTERVAL_RST;
            errors      = 0;
            for (int p = 0; p < PORTS; p++) begin
                held[p]        = '0;
                press_acc[p]   = '0;
                release_acc[p] = '0;
                repeat_acc[p]  = '0;
                last_x[p]      = '0;
                last_y[p]      = '0;
                countdown[p]   = int'(FIRST_DELAY_RST);
                faulted[p]     = 1'b0;
                snaps[p]       = '0;
            end
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_FIRST_DELAY) begin
                first_delay = value;
            end else begin
                interval = value;
            end
        endfunction

        function int pending();
            return snapshot_q.size();
        endfunction

        function void note_item(item_t it);
            int               p;
            logic [BTN_W-1:0] diff;
            logic [BTN_W-1:0] presses;
            logic [BTN_W-1:0] releases;
            logic [BTN_W-1:0] rep;
            result_t          r;
            p = it.port;
            if (it.cmd == CMD_SAMPLE) begin
                faulted[p] = it.fault;
                if (!it.fault) begin
                    diff     = it.buttons ^ held[p];
                    presses  = diff & it.buttons;
                    releases = diff & held[p];
                    if (diff != '0) begin
                        rep          = presses;
                        countdown[p] = int'(first_delay);
                    end else begin
                        countdown[p] = countdown[p] - 1;
                        if (countdown[p] > 0) begin
                            rep = '0;
                        end else begin
                            rep          = it.buttons;
                            countdown[p] = int'(interval);
                        end
                    end
                    held[p]        = it.buttons;
                    last_x[p]      = it.stick_x;
                    last_y[p]      = it.stick_y;
                    press_acc[p]   = press_acc[p] | presses;
                    release_acc[p] = release_acc[p] | releases;
                    repeat_acc[p]  = repeat_acc[p] | rep;
                end
            end else begin
                if (!faulted[p]) begin
                    snaps[p].held     = held[p];
                    snaps[p].pressed  = press_acc[p];
                    snaps[p].repeats  = repeat_acc[p];
                    snaps[p].released = release_acc[p];
                    snaps[p].stick_x  = last_x[p];
                    snaps[p].stick_y  = last_y[p];
                    press_acc[p]      = '0;
                    release_acc[p]    = '0;
                    repeat_acc[p]     = '0;
                end
                r.snap    = snaps[p];
                r.faulted = faulted[p];
                snapshot_q.push_back(r);
            end
        endfunction

        function void compare_field(string label, logic [BTN_W-1:0] want,
                                    logic [BTN_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", label, want, got);
                errors++;
            end
        endfunction

        function void check_snapshot(result_t got);
            result_t want;
            if (snapshot_q.size() == 0) begin
                $error("snapshot transfer with none outstanding");
                errors++;
                return;
            end
            want = snapshot_q.pop_front();
            compare_field("held_buttons", want.snap.held, got.snap.held);
            compare_field("pressed_since", want.snap.pressed, got.snap.pressed);
            compare_field("repeat_since", want.snap.repeats, got.snap.repeats);
            compare_field("released_since", want.snap.released, got.snap.released);
            compare_field("stick_out_x", 16'(want.snap.stick_x), 16'(got.snap.stick_x));
            compare_field("stick_out_y", 16'(want.snap.stick_y), 16'(got.snap.stick_y));
            compare_field("port_faulted", 16'(want.faulted), 16'(got.faulted));
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]     pwdata;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_cmd;
    logic [PORT_W-1:0]         s_port;
    logic [BTN_W-1:0]          s_buttons_now;
    logic signed [STICK_W-1:0] s_stick_horizontal;
    logic signed [STICK_W-1:0] s_stick_vertical;
    logic                      s_read_fault;
    logic                      m_valid;
    logic                      m_ready;
    logic [BTN_W-1:0]          m_held_buttons;
    logic [BTN_W-1:0]          m_pressed_since;
    logic [BTN_W-1:0]          m_repeat_since;
    logic [BTN_W-1:0]          m_released_since;
    logic signed [STICK_W-1:0] m_stick_out_x;
    logic signed [STICK_W-1:0] m_stick_out_y;
    logic                      m_port_faulted;

    snapshot_scoreboard sb;
    bit                 steady;
    int                 stall_cycles;
    logic [BTN_W-1:0]   recent_buttons [PORTS];
    item_t              seen_item;
    result_t            seen_snap;

    logic [CFG_W-1:0] phase_delay [PHASES] = '{16'd0, 16'd65535, 16'd2, 16'd1,
                                               16'd65535, 16'd7, 16'd0};
    logic [CFG_W-1:0] phase_interval [PHASES] = '{16'd0, 16'd65535, 16'd1, 16'd0,
                                                  16'd3, 16'd65535, 16'd2};

    button_edge_autorepeat_latch_core #(
        .PORT_COUNT(PORTS)
    ) uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_port             (s_port),
        .s_buttons_now      (s_buttons_now),
        .s_stick_horizontal (s_stick_horizontal),
        .s_stick_vertical   (s_stick_vertical),
        .s_read_fault       (s_read_fault),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_held_buttons     (m_held_buttons),
        .m_pressed_since    (m_pressed_since),
        .m_repeat_since     (m_repeat_since),
        .m_released_since   (m_released_since),
        .m_stick_out_x      (m_stick_out_x),
        .m_stick_out_y      (m_stick_out_y),
        .m_port_faulted     (m_port_faulted)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_snap.snap.held     = m_held_buttons;
                seen_snap.snap.pressed  = m_pressed_since;
                seen_snap.snap.repeats  = m_repeat_since;
                seen_snap.snap.released = m_released_since;
                seen_snap.snap.stick_x  = m_stick_out_x;
                seen_snap.snap.stick_y  = m_stick_out_y;
                seen_snap.faulted       = m_port_faulted;
                sb.check_snapshot(seen_snap);
            end
            if (s_valid && s_ready) begin
                seen_item.cmd     = s_cmd;
                seen_item.port    = s_port;
                seen_item.buttons = s_buttons_now;
                seen_item.stick_x = s_stick_horizontal;
                seen_item.stick_y = s_stick_vertical;
                seen_item.fault   = s_read_fault;
                sb.note_item(seen_item);
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input item_t it);
        if (!steady && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_cmd              <= it.cmd;
        s_port             <= it.port;
        s_buttons_now      <= it.buttons;
        s_stick_horizontal <= it.stick_x;
        s_stick_vertical   <= it.stick_y;
        s_read_fault       <= it.fault;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic sample(input int p, input logic [BTN_W-1:0] buttons,
                          input logic signed [STICK_W-1:0] x,
                          input logic signed [STICK_W-1:0] y, input logic fault);
        item_t it;
        it.cmd     = CMD_SAMPLE;
        it.port    = PORT_W'(p);
        it.buttons = buttons;
        it.stick_x = x;
        it.stick_y = y;
        it.fault   = fault;
        send_item(it);
    endtask

    task automatic publish(input int p);
        item_t it;
        it         = '0;
        it.cmd     = CMD_PUBLISH;
        it.port    = PORT_W'(p);
        it.buttons = BTN_W'($urandom);
        send_item(it);
    endtask

    // Drain, let the pipeline empty, then rewrite both repeat registers.
    task automatic program_repeat(input logic [CFG_W-1:0] delay,
                                  input logic [CFG_W-1:0] gap);
        logic [CFG_W-1:0] values [2];
        logic             idx [2];
        values = '{delay, gap};
        idx    = '{REG_FIRST_DELAY, REG_INTERVAL};
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        for (int k = 0; k < 2; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx[k], 2'b00};
            pwdata  <= APB_DATA_W'(values[k]);
            @(negedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            sb.write_reg(idx[k], values[k]);
            @(negedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic item_t random_item();
        item_t it;
        int    pick;
        it.port    = PORT_W'($urandom_range(0, PORTS - 1));
        it.cmd     = ($urandom_range(0, 99) < 22) ? CMD_PUBLISH : CMD_SAMPLE;
        it.stick_x = STICK_W'($urandom_range(0, 255));
        it.stick_y = STICK_W'($urandom_range(0, 255));
        it.fault   = ($urandom_range(0, 99) < 8);
        pick       = $urandom_range(0, 99);
        if (pick < 60) begin
            it.buttons = recent_buttons[it.port];
        end else if (pick < 85) begin
            it.buttons = recent_buttons[it.port] ^ (BTN_W'(1) << $urandom_range(0, 15))
                         ^ (BTN_W'($urandom_range(0, 1)) << $urandom_range(0, 15));
        end else begin
            it.buttons = BTN_W'($urandom);
        end
        if (it.cmd == CMD_SAMPLE) begin
            recent_buttons[it.port] = it.buttons;
        end
        return it;
    endfunction

    initial begin
        aresetn            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        s_valid            = 1'b0;
        s_cmd              = CMD_SAMPLE;
        s_port             = '0;
        s_buttons_now      = '0;
        s_stick_horizontal = '0;
        s_stick_vertical   = '0;
        s_read_fault       = 1'b0;
        steady             = 1'b0;
        for (int p = 0; p < PORTS; p++) recent_buttons[p] = '0;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset snapshot, full press and release, sticks at both extremes
        publish(0);
        sample(1, 16'hFFFF, 8'sh7F, 8'sh80, 1'b0);
        publish(1);
        sample(1, 16'h0000, 8'sh80, 8'sh7F, 1'b0);
        publish(1);
        // faulted port keeps its old snapshot
        sample(2, 16'h00A5, 8'sh01, 8'sh02, 1'b1);
        publish(2);
        sample(2, 16'h00A5, 8'sh03, 8'sh04, 1'b0);
        publish(2);
        sample(2, 16'h5A00, 8'sh05, 8'sh06, 1'b1);
        publish(2);
        sample(2, 16'h5A00, 8'sh07, 8'sh08, 1'b0);
        publish(2);
        // zero delay and interval: repeat on every unchanged sample
        program_repeat(16'd0, 16'd0);
        sample(3, 16'h8001, 8'sh10, 8'sh20, 1'b0);
        sample(3, 16'h8001, 8'sh11, 8'sh21, 1'b0);
        publish(3);
        sample(3, 16'h8001, 8'sh12, 8'sh22, 1'b0);
        sample(3, 16'h8001, 8'sh13, 8'sh23, 1'b0);
        publish(3);
        publish(3);
        recent_buttons[1] = 16'h0000;
        recent_buttons[2] = 16'h5A00;
        recent_buttons[3] = 16'h8001;

        for (int ph = 0; ph < PHASES; ph++) begin
            program_repeat(phase_delay[ph], phase_interval[ph]);
            steady = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item());
            end
        end
        steady = 1'b0;

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
src/beal_pkg.sv
src/beal_regs.sv
src/beal_in_stage.sv
src/beal_port_bank.sv
src/beal_out_stage.sv
src/button_edge_autorepeat_latch_core.sv
tb/sv/tb_top.sv
